### src/btp_pkg.sv
// Shared constants and types for the binary thinning pass unit.
package btp_pkg;

    // Configuration register field widths
    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_REG_W = 13;
    localparam int unsigned CFG_DATA_W   = 13;
    localparam int unsigned CFG_INDEX_W  = 2;

    // Result field widths
    localparam int unsigned ROW_FIELD_W = 12;
    localparam int unsigned COL_FIELD_W = 10;

    // Smallest image side; smaller settings act as this
    localparam int unsigned MIN_SIDE = 4;

    // Deletion rule: set-neighbour range and required transition count
    localparam int unsigned COUNT_LOW      = 2;
    localparam int unsigned COUNT_HIGH     = 6;
    localparam int unsigned ONE_TRANSITION = 1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_PARITY = 2'd2
    } t_cfg_index;

    // One buffered result
    typedef struct packed {
        logic                   pix;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } t_result;

endpackage

### src/binary_thinning_pass_unit.sv
// Top level: one Zhang-Suen thinning sub-iteration over a raster pixel stream.
//
// Input stream (s_axis): one binary pixel per transfer in raster order, bit 0 of tdata.
// Output stream (m_axis): pixel_out, out_row, out_col in tdata; tlast marks the last
// result caused by one input pixel. An input pixel yields zero, one or two results:
// border pixels pass through unchanged in the step they arrive, an interior pixel is
// decided and emitted when the pixel below and right of it arrives. When two results
// come from one pixel the delayed interior one goes first.
// Configuration (i_cfg_*): always ready; index 0 image width, 1 image height,
// 2 pass parity. Writing width or height restarts the image at row 0, column 0.
// Write only while the stream is idle.
// A result passes the line store read register, then the result register, after its
// causing input transfer. Throughput: one pixel per cycle while each pixel yields at most
// one result and the receiver does not stall; a pixel with two results holds the single
// output port for both of them, so the last row and last column run slower.
// The line stores are one 2-bit-wide memory, read once and written once per pixel.
// Reset: registers return to 640x480, parity 0, position 0; the line memory is not
// cleared, its stale contents are never used for a decision.
// Receiver stall: the result register holds, the input stage fills, then
// s_axis_tready drops until results drain.
module binary_thinning_pass_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel input; tdata: [0] pixel_in, [7:1] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,
    // Result output; tdata: [0] pixel_out, [12:1] out_row, [22:13] out_col, [23] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    // Configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [btp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [btp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration registers
    logic [btp_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [btp_pkg::HEIGHT_REG_W-1:0] r_height;
    logic                             r_parity;

    // Position of the next pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Input stage
    logic          r_a_valid;
    logic          r_a_pix;
    logic [CW-1:0] r_a_col;
    logic [RW-1:0] r_a_row;
    logic [1:0]    r_a_line;     // [0] two rows up, [1] one row up

    // Line memory: per column {one row up, two rows up}
    logic [1:0] r_line_mem [MAX_WIDTH];

    // Window and result buffer
    logic [8:0]        r_win;
    logic [8:0]        n_win;
    logic              r_o0_valid;
    logic              r_o1_valid;
    btp_pkg::t_result  r_o0;
    btp_pkg::t_result  r_o1;

    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic          cfg_take;
    logic          in_take;
    logic          out_take;
    logic          out_free;
    logic          a_adv;
    logic          interior;
    logic          border;
    logic          centre_pix;
    btp_pkg::t_result out_sel;

    // Clamp image sides into [MIN_SIDE, MAX]
    always_comb begin
        if (r_width < btp_pkg::WIDTH_REG_W'(btp_pkg::MIN_SIDE)) begin
            w_last = CW'(btp_pkg::MIN_SIDE - 1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - btp_pkg::WIDTH_REG_W'(1));
        end
    end

    always_comb begin
        if (r_height < btp_pkg::HEIGHT_REG_W'(btp_pkg::MIN_SIDE)) begin
            h_last = RW'(btp_pkg::MIN_SIDE - 1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_height - btp_pkg::HEIGHT_REG_W'(1));
        end
    end

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign cfg_take      = i_cfg_valid & o_cfg_ready;
    assign out_take      = m_axis_tvalid & m_axis_tready;
    assign out_free      = !(r_o0_valid || r_o1_valid)
                        || (out_take && !(r_o0_valid && r_o1_valid));
    assign a_adv         = r_a_valid & out_free;
    assign s_axis_tready = !r_a_valid || out_free;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    // Configuration writes; size writes restart the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= btp_pkg::WIDTH_REG_W'(640);
            r_height <= btp_pkg::HEIGHT_REG_W'(480);
            r_parity <= 1'b0;
        end else if (cfg_take) begin
            case (btp_pkg::t_cfg_index'(i_cfg_index))
                btp_pkg::CFG_WIDTH: begin
                    r_width <= i_cfg_data[btp_pkg::WIDTH_REG_W-1:0];
                end
                btp_pkg::CFG_HEIGHT: begin
                    r_height <= i_cfg_data[btp_pkg::HEIGHT_REG_W-1:0];
                end
                btp_pkg::CFG_PARITY: begin
                    r_parity <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_take && (i_cfg_index == btp_pkg::CFG_WIDTH
                               || i_cfg_index == btp_pkg::CFG_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_take) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= (r_row == h_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    // Input stage payload and line memory read
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_pix  <= s_axis_tdata[0];
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_line <= r_line_mem[r_col];
        end
    end

    // Line memory update as the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_line_mem[r_a_col] <= {r_a_pix, r_a_line[1]};
        end
    end

    // Shift the new column into the window
    assign n_win = {r_a_pix, r_a_line[1], r_a_line[0], r_win[8:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= n_win;
        end
    end

    btp_centre u_centre (
        .i_win    (n_win),
        .i_parity (r_parity),
        .o_pix    (centre_pix)
    );

    assign interior = (r_a_row >= RW'(2)) && (r_a_col >= CW'(2));
    assign border   = (r_a_row == '0) || (r_a_row == h_last)
                   || (r_a_col == '0) || (r_a_col == w_last);

    // Result buffer: slot 0 delayed interior, slot 1 arriving border
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o0_valid <= 1'b0;
            r_o1_valid <= 1'b0;
        end else if (a_adv) begin
            r_o0_valid <= interior;
            r_o1_valid <= border;
        end else if (out_take) begin
            if (r_o0_valid) begin
                r_o0_valid <= 1'b0;
            end else begin
                r_o1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o0.pix <= centre_pix;
            r_o0.row <= btp_pkg::ROW_FIELD_W'(r_a_row - RW'(1));
            r_o0.col <= btp_pkg::COL_FIELD_W'(r_a_col - CW'(1));
            r_o1.pix <= r_a_pix;
            r_o1.row <= btp_pkg::ROW_FIELD_W'(r_a_row);
            r_o1.col <= btp_pkg::COL_FIELD_W'(r_a_col);
        end
    end

    // Output selection
    assign out_sel       = r_o0_valid ? r_o0 : r_o1;
    assign m_axis_tvalid = r_o0_valid | r_o1_valid;
    assign m_axis_tlast  = r_o0_valid ? !r_o1_valid : 1'b1;
    assign m_axis_tdata  = {1'b0, out_sel.col, out_sel.row, out_sel.pix};

endmodule

### src/btp_centre.sv
// Zhang-Suen deletion decision for the centre of a 3x3 window.
module btp_centre (
    input  logic [8:0] i_win,     // bit col*3+row, col 0 is leftmost, row 0 is top
    input  logic       i_parity,
    output logic       o_pix
);

    logic       nw, no, ne, we, me, ea, sw, so, se;
    logic [7:0] ring;
    logic [3:0] trans;
    logic [3:0] count;
    logic       m1, m2;
    logic       del;

    assign nw = i_win[0];
    assign we = i_win[1];
    assign sw = i_win[2];
    assign no = i_win[3];
    assign me = i_win[4];
    assign so = i_win[5];
    assign ne = i_win[6];
    assign ea = i_win[7];
    assign se = i_win[8];

    // Neighbours clockwise from north
    assign ring = {nw, we, sw, so, se, ea, ne, no};

    // 0-to-1 transitions and set-neighbour count around the ring
    always_comb begin
        trans = '0;
        count = '0;
        for (int i = 0; i < 8; i++) begin
            if (!ring[i] && ring[(i + 1) % 8]) begin
                trans = trans + 4'd1;
            end
            count = count + 4'(ring[i]);
        end
    end

    // Parity-dependent neighbour products
    always_comb begin
        if (!i_parity) begin
            m1 = no & ea & so;
            m2 = ea & so & we;
        end else begin
            m1 = no & ea & we;
            m2 = no & so & we;
        end
    end

    assign del = (trans == 4'(btp_pkg::ONE_TRANSITION))
              && (count >= 4'(btp_pkg::COUNT_LOW))
              && (count <= 4'(btp_pkg::COUNT_HIGH))
              && !m1 && !m2;

    assign o_pix = me & ~del;

endmodule
